// File: design/wtsp_pkg.sv
// Shared types and constants for the WebAssembly type section parser.
// Holds event kinds, error codes, value-type checks and the result record.
// No dependencies.
`default_nettype none

package wtsp_pkg;

    // Event kinds carried by a result transaction
    localparam logic [1:0] KIND_PARAM = 2'd0;
    localparam logic [1:0] KIND_FUNC  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Error codes
    localparam logic [2:0] ERR_NONE         = 3'd0;
    localparam logic [2:0] ERR_BAD_FORM     = 3'd1;
    localparam logic [2:0] ERR_BAD_TYPE     = 3'd2;
    localparam logic [2:0] ERR_MANY_RESULTS = 3'd3;
    localparam logic [2:0] ERR_TRUNCATED    = 3'd4;
    localparam logic [2:0] ERR_OVERLONG     = 3'd5;

    // Function type form byte, value-type code ranges and the parameter count limit
    localparam logic [31:0] FORM_FUNC   = 32'h0000_0060;
    localparam logic [31:0] NUM_TYPE_LO = 32'h0000_007B;
    localparam logic [31:0] NUM_TYPE_HI = 32'h0000_007F;
    localparam logic [31:0] REF_TYPE_LO = 32'h0000_0071;
    localparam logic [31:0] REF_TYPE_HI = 32'h0000_0074;
    localparam logic [31:0] MAX_PARAMS  = 32'h0000_00FF;

    // Result queue sizing
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = 2;
    localparam int RES_CNT_W = 3;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic [31:0] type_index;
        logic [7:0]  param_position;
        logic [6:0]  value_type;
        logic        result_present;
        logic [2:0]  error_code;
        logic        last_of_run;
    } result_t;

    function automatic logic is_value_type(input logic [31:0] v);
        return ((v >= NUM_TYPE_LO) && (v <= NUM_TYPE_HI))
            || ((v >= REF_TYPE_LO) && (v <= REF_TYPE_HI));
    endfunction

endpackage

`default_nettype wire

// File: design/wasm_type_section_parser_unit.sv
// Top level of the WebAssembly type section parser: byte decoder and result queue.
// Depends on wtsp_pkg for the result record, event kinds and error codes.
`default_nettype none

// Usage
// Input channel (in_valid / in_stall): one section byte per transaction, with
//   section_last high on the final byte of the section.
// Output channel (out_valid / out_stall): one event per transaction: a
//   parameter type, a completed function type, or an error.
// Each accepted byte is decoded in the cycle it is accepted: the LEB128
//   accumulator, phase and counters update at that clock edge, and the zero,
//   one or two events it causes are written to a four-entry result queue.
// An event is offered on the output once it reaches the head of the queue.
// Throughput: one byte per cycle while the receiver keeps up; a byte that
//   causes two events (a final byte that also truncates) writes both at once,
//   and the queue absorbs the extra event.
// in_stall rises when fewer than two queue entries are free, so a stalled
//   receiver holds the head event steady and back-pressures the source.
// Reset clears the decoder to "expecting type count" and empties the queue.
// After an error, bytes are dropped until the final byte of the section,
//   which returns the parser to its reset state.
module wasm_type_section_parser_unit
    import wtsp_pkg::*;
#(
    parameter int MAX_LEB_BYTES = 5
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        section_last,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       event_kind,
    output logic [31:0]      type_index,
    output logic [7:0]       param_position,
    output logic [6:0]       value_type,
    output logic             result_present,
    output logic [2:0]       error_code,
    output logic             last_of_run
);

    localparam int CNT_W = $clog2(MAX_LEB_BYTES + 1);
    localparam int SH_W  = $clog2(7 * MAX_LEB_BYTES);

    typedef enum logic [2:0] {
        PH_COUNT,
        PH_FORM,
        PH_NPARAM,
        PH_PARAM,
        PH_NRESULT,
        PH_RESULT,
        PH_DONE
    } phase_t;

    // Decoder state
    phase_t             phase_reg,      phase_next;
    logic [31:0]        acc_reg,        acc_next;
    logic [CNT_W-1:0]   cnt_reg,        cnt_next;
    logic [31:0]        types_left_reg, types_left_next;
    logic [31:0]        cur_type_reg,   cur_type_next;
    logic [7:0]         ptotal_reg,     ptotal_next;
    logic [7:0]         pseen_reg,      pseen_next;
    logic               hold_reg,       hold_next;

    // Result queue
    result_t                res_mem [RES_DEPTH];
    logic [RES_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [RES_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [RES_CNT_W-1:0]   count_reg,  count_next;

    logic           in_acc;
    logic           out_acc;
    logic           active;
    logic [SH_W-1:0] shamt;
    logic [31:0]    acc_full;
    logic [7:0]     pseen_inc;
    logic [31:0]    left_dec;
    logic           r0_valid;
    logic           r1_valid;
    result_t        r0;
    result_t        r1;
    result_t        push_first;
    logic [1:0]     n_push;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;

    // Hold the source off unless two free entries remain
    assign in_stall  = (count_reg > RES_CNT_W'(RES_DEPTH - 2));
    assign out_valid = (count_reg != '0);

    assign active    = !hold_reg && (phase_reg != PH_DONE);
    assign shamt     = SH_W'(cnt_reg) * SH_W'(7);
    assign acc_full  = acc_reg | (32'(data_byte[6:0]) << shamt);
    assign pseen_inc = pseen_reg + 8'd1;
    assign left_dec  = types_left_reg - 32'd1;

    // Byte decoder: next state and the events caused by this byte
    always_comb
    begin
        phase_next      = phase_reg;
        acc_next        = acc_reg;
        cnt_next        = cnt_reg;
        types_left_next = types_left_reg;
        cur_type_next   = cur_type_reg;
        ptotal_next     = ptotal_reg;
        pseen_next      = pseen_reg;
        hold_next       = hold_reg;
        r0_valid        = 1'b0;
        r0              = '0;
        r0.type_index   = cur_type_reg;
        r1_valid        = 1'b0;
        r1              = '0;

        if (active)
        begin
            acc_next = acc_full;
            if (data_byte[7])
            begin
                // Continuation byte: grow the number or flag it as overlong
                if (({1'b0, cnt_reg} + (CNT_W + 1)'(1)) >= (CNT_W + 1)'(MAX_LEB_BYTES))
                begin
                    r0_valid      = 1'b1;
                    r0.event_kind = KIND_ERROR;
                    r0.error_code = ERR_OVERLONG;
                    hold_next     = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            else
            begin
                acc_next = '0;
                cnt_next = '0;
                unique case (phase_reg)
                    PH_COUNT:
                    begin
                        types_left_next = acc_full;
                        cur_type_next   = '0;
                        phase_next      = (acc_full == '0) ? PH_DONE : PH_FORM;
                    end
                    PH_FORM:
                    begin
                        if (acc_full != FORM_FUNC)
                        begin
                            r0_valid      = 1'b1;
                            r0.event_kind = KIND_ERROR;
                            r0.error_code = ERR_BAD_FORM;
                            hold_next     = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_NPARAM;
                        end
                    end
                    PH_NPARAM:
                    begin
                        if (acc_full > MAX_PARAMS)
                        begin
                            r0_valid      = 1'b1;
                            r0.event_kind = KIND_ERROR;
                            r0.error_code = ERR_OVERLONG;
                            hold_next     = 1'b1;
                        end
                        else
                        begin
                            ptotal_next = acc_full[7:0];
                            pseen_next  = '0;
                            phase_next  = (acc_full == '0) ? PH_NRESULT : PH_PARAM;
                        end
                    end
                    PH_PARAM:
                    begin
                        r0_valid = 1'b1;
                        if (!is_value_type(acc_full))
                        begin
                            r0.event_kind = KIND_ERROR;
                            r0.error_code = ERR_BAD_TYPE;
                            hold_next     = 1'b1;
                        end
                        else
                        begin
                            r0.event_kind     = KIND_PARAM;
                            r0.param_position = pseen_reg;
                            r0.value_type     = acc_full[6:0];
                            pseen_next        = pseen_inc;
                            if (pseen_inc >= ptotal_reg)
                            begin
                                phase_next = PH_NRESULT;
                            end
                        end
                    end
                    PH_NRESULT:
                    begin
                        if (acc_full > 32'd1)
                        begin
                            r0_valid      = 1'b1;
                            r0.event_kind = KIND_ERROR;
                            r0.error_code = ERR_MANY_RESULTS;
                            hold_next     = 1'b1;
                        end
                        else if (acc_full == '0)
                        begin
                            r0_valid          = 1'b1;
                            r0.event_kind     = KIND_FUNC;
                            r0.param_position = ptotal_reg;
                            cur_type_next     = cur_type_reg + 32'd1;
                            types_left_next   = left_dec;
                            phase_next        = (left_dec == '0) ? PH_DONE : PH_FORM;
                        end
                        else
                        begin
                            phase_next = PH_RESULT;
                        end
                    end
                    PH_RESULT:
                    begin
                        r0_valid = 1'b1;
                        if (!is_value_type(acc_full))
                        begin
                            r0.event_kind = KIND_ERROR;
                            r0.error_code = ERR_BAD_TYPE;
                            hold_next     = 1'b1;
                        end
                        else
                        begin
                            r0.event_kind     = KIND_FUNC;
                            r0.param_position = ptotal_reg;
                            r0.value_type     = acc_full[6:0];
                            r0.result_present = 1'b1;
                            cur_type_next     = cur_type_reg + 32'd1;
                            types_left_next   = left_dec;
                            phase_next        = (left_dec == '0) ? PH_DONE : PH_FORM;
                        end
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end

        // Final byte: flag an unfinished section, then return to reset state
        if (section_last)
        begin
            if (!hold_next && (phase_next != PH_DONE))
            begin
                r1_valid      = 1'b1;
                r1.event_kind = KIND_ERROR;
                r1.type_index = cur_type_next;
                r1.error_code = ERR_TRUNCATED;
            end
            phase_next      = PH_COUNT;
            acc_next        = '0;
            cnt_next        = '0;
            types_left_next = '0;
            cur_type_next   = '0;
            ptotal_next     = '0;
            pseen_next      = '0;
            hold_next       = 1'b0;
        end

        // Mark the final event of this byte
        if (r1_valid)
        begin
            r1.last_of_run = 1'b1;
        end
        else
        begin
            r0.last_of_run = 1'b1;
        end
    end

    // Queue bookkeeping
    always_comb
    begin
        push_first  = r0_valid ? r0 : r1;
        n_push      = in_acc ? (2'(r0_valid) + 2'(r1_valid)) : 2'd0;
        wr_ptr_next = wr_ptr_reg + RES_PTR_W'(n_push);
        rd_ptr_next = rd_ptr_reg + RES_PTR_W'(out_acc);
        count_next  = count_reg + RES_CNT_W'(n_push) - RES_CNT_W'(out_acc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_COUNT;
            acc_reg        <= '0;
            cnt_reg        <= '0;
            types_left_reg <= '0;
            cur_type_reg   <= '0;
            ptotal_reg     <= '0;
            pseen_reg      <= '0;
            hold_reg       <= 1'b0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
        end
        else
        begin
            if (in_acc)
            begin
                phase_reg      <= phase_next;
                acc_reg        <= acc_next;
                cnt_reg        <= cnt_next;
                types_left_reg <= types_left_next;
                cur_type_reg   <= cur_type_next;
                ptotal_reg     <= ptotal_next;
                pseen_reg      <= pseen_next;
                hold_reg       <= hold_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage: up to two writes per accepted byte
    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
        begin
            res_mem[wr_ptr_reg] <= push_first;
        end
        if (n_push == 2'd2)
        begin
            res_mem[wr_ptr_reg + RES_PTR_W'(1)] <= r1;
        end
    end

    // Present the head of the queue
    assign event_kind     = res_mem[rd_ptr_reg].event_kind;
    assign type_index     = res_mem[rd_ptr_reg].type_index;
    assign param_position = res_mem[rd_ptr_reg].param_position;
    assign value_type     = res_mem[rd_ptr_reg].value_type;
    assign result_present = res_mem[rd_ptr_reg].result_present;
    assign error_code     = res_mem[rd_ptr_reg].error_code;
    assign last_of_run    = res_mem[rd_ptr_reg].last_of_run;

    // Queue never overfills
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= RES_CNT_W'(RES_DEPTH))
        else $error("result queue overflow");

    // Error hold is only ever raised mid-section
    assert property (@(posedge clk) disable iff (!rst_n)
        hold_reg |-> (phase_reg != PH_DONE))
        else $error("error hold with section complete");

    // Final byte returns the decoder to its reset state
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && section_last) |=> ((phase_reg == PH_COUNT) && !hold_reg
                                      && (cnt_reg == '0)))
        else $error("decoder not cleared after final byte");

    // While reading parameter types, some remain to be read
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PARAM) |-> (pseen_reg < ptotal_reg))
        else $error("parameter count overrun");

    // Number length never reaches the limit
    assert property (@(posedge clk) disable iff (!rst_n)
        (CNT_W + 1)'(cnt_reg) < (CNT_W + 1)'(MAX_LEB_BYTES))
        else $error("LEB byte count past limit");

endmodule

`default_nettype wire
